>>> hdl/matrix_keypad_change_detector_assert.svh
// ---------------------------------------------------------------------------
// Keypad change detector assertion macros
// Shared concurrent assertion forms, clocked on clk_i, off during reset.
// ---------------------------------------------------------------------------
`ifndef MATRIX_KEYPAD_CHANGE_DETECTOR_ASSERT_SVH
`define MATRIX_KEYPAD_CHANGE_DETECTOR_ASSERT_SVH

// Same-cycle implication
`define MKCD_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define MKCD_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/mkcd_pkg.sv
// ---------------------------------------------------------------------------
// Keypad change detector package
// Payload types, job record, pin packing and key suppression helpers.
// ---------------------------------------------------------------------------
package mkcd_pkg;

  localparam int unsigned MaxRows = 10;
  localparam int unsigned CodeW   = 7;
  localparam int unsigned PinW    = 13;

  localparam logic [PinW-1:0] PinMask  = 13'h1E3F;
  localparam logic [PinW-1:0] HighPins = 13'h1E00;
  localparam logic [PinW-1:0] LowPins  = 13'h003F;

  // Result kinds
  localparam logic KindEvent   = 1'b0;
  localparam logic KindSummary = 1'b1;

  // Key indices muted while the display is off
  localparam int unsigned NumSupp = 5;
  localparam logic [CodeW-1:0] SuppKeys [NumSupp] = '{7'd5, 7'd15, 7'd25, 7'd35, 7'd44};

  typedef struct packed {
    logic [2:0]      column;
    logic [PinW-1:0] row_pins;
    logic            display_on;
    logic            last_column;
  } col_req_t;

  typedef struct packed {
    logic             kind;
    logic [CodeW-1:0] keycode;
    logic             pressed;
    logic             any_held;
    logic             last;
  } evt_t;

  // Work handed from the detector to the serializer
  typedef struct packed {
    logic [MaxRows-1:0] press;
    logic [MaxRows-1:0] rel;
    logic [CodeW-1:0]   base;
    logic               summary;
    logic               held;
  } job_t;

  // Invert active-low pins, keep pins 0..5 and 9..12, close the gap
  function automatic logic [MaxRows-1:0] pack_rows(logic [PinW-1:0] pins);
    logic [PinW-1:0] raw;
    logic [PinW-1:0] packed_pins;
    raw         = ~pins & PinMask;
    packed_pins = ((raw & HighPins) >> 3) | (raw & LowPins);
    return packed_pins[MaxRows-1:0];
  endfunction

  function automatic logic is_suppressed(logic [CodeW-1:0] idx);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < NumSupp; i++) begin
      hit = hit | (idx == SuppKeys[i]);
    end
    return hit;
  endfunction

endpackage

>>> hdl/mkcd_col_if.sv
// ---------------------------------------------------------------------------
// Keypad column channel
// Valid/ready channel carrying one scanned column request.
// ---------------------------------------------------------------------------
interface mkcd_col_if import mkcd_pkg::*; ();
  logic     valid;
  logic     ready;
  col_req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> hdl/mkcd_evt_if.sv
// ---------------------------------------------------------------------------
// Keypad event channel
// Valid/ready channel carrying key events and scan summaries.
// ---------------------------------------------------------------------------
interface mkcd_evt_if import mkcd_pkg::*; ();
  logic valid;
  logic ready;
  evt_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> hdl/mkcd_detect.sv
// ---------------------------------------------------------------------------
// Keypad column change detector
// Compares a scanned column with its stored mask, builds the press and
// release masks for one request and keeps the held accumulator.
// ---------------------------------------------------------------------------
module mkcd_detect import mkcd_pkg::*; #(
  parameter int unsigned COLUMNS = 8,
  parameter int unsigned ROWS    = 10
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  mkcd_col_if.sink    col_i,
  output job_t        job_o,
  output logic        job_valid_o,
  input  logic        job_ready_i
);

  localparam int unsigned ColW = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;

  logic [ROWS-1:0] prev_q [COLUMNS];
  logic            held_q, held_d;
  job_t            job_q, job_d;
  logic            job_valid_q;

  logic [MaxRows-1:0] rows_all;
  logic [ROWS-1:0]    rows, prev, supp, press, rel;
  logic               in_range, col_held, job_has, accept;
  logic [ColW-1:0]    col_idx;
  logic [CodeW-1:0]   base;

  assign col_i.ready = !job_valid_q || job_ready_i;
  assign accept      = col_i.valid && col_i.ready;

  // Change masks for the presented column
  always_comb begin
    rows_all = pack_rows(col_i.data.row_pins);
    rows     = rows_all[ROWS-1:0];
    in_range = (32'(col_i.data.column) < COLUMNS);
    col_idx  = col_i.data.column[ColW-1:0];
    prev     = in_range ? prev_q[col_idx] : '0;
    base     = CodeW'(32'(col_i.data.column) * ROWS);
    for (int r = 0; r < ROWS; r++) begin
      supp[r] = !col_i.data.display_on && is_suppressed(base + CodeW'(r));
    end
    press    = rows & ~prev & ~supp & {ROWS{in_range}};
    rel      = prev & ~rows & ~supp & {ROWS{in_range}};
    col_held = in_range && (|rows);

    job_d               = '0;
    job_d.press[ROWS-1:0] = press;
    job_d.rel[ROWS-1:0]   = rel;
    job_d.base          = base;
    job_d.summary       = col_i.data.last_column;
    job_d.held          = held_q | col_held;
    job_has             = (|press) || (|rel) || col_i.data.last_column;

    held_d = col_i.data.last_column ? 1'b0 : (held_q | col_held);
  end

  // Column store, accumulator and job register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < COLUMNS; c++) begin
        prev_q[c] <= '0;
      end
      held_q      <= 1'b0;
      job_valid_q <= 1'b0;
    end else if (accept) begin
      if (in_range) begin
        prev_q[col_idx] <= rows;
      end
      held_q      <= held_d;
      job_valid_q <= job_has;
    end else if (job_ready_i) begin
      job_valid_q <= 1'b0;
    end
  end

  // Job payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (accept) begin
      job_q <= job_d;
    end
  end

  assign job_o       = job_q;
  assign job_valid_o = job_valid_q;

endmodule

>>> hdl/mkcd_serial.sv
// ---------------------------------------------------------------------------
// Keypad event serializer
// Emits the events of one job one per cycle while the output register is free:
// presses in ascending row order, then releases, then the scan summary.
// ---------------------------------------------------------------------------
`include "matrix_keypad_change_detector_assert.svh"

module mkcd_serial import mkcd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  job_t       job_i,
  input  logic       job_valid_i,
  output logic       job_ready_o,
  mkcd_evt_if.source evt_o
);

  localparam int unsigned RowIdxW = $clog2(MaxRows);

  job_t  work_q, work_d, work_nx;
  evt_t  out_q, evt;
  logic  out_valid_q;

  logic               busy, out_free, emit, busy_after;
  logic [MaxRows-1:0] sel;
  logic [RowIdxW-1:0] r_idx;

  assign busy     = (|work_q.press) || (|work_q.rel) || work_q.summary;
  assign out_free = !out_valid_q || evt_o.ready;
  assign emit     = out_free && busy;

  // Pick the next result of the current job
  always_comb begin
    sel   = (|work_q.press) ? work_q.press : work_q.rel;
    r_idx = '0;
    for (int r = MaxRows - 1; r >= 0; r--) begin
      if (sel[r]) begin
        r_idx = RowIdxW'(r);
      end
    end

    work_nx      = work_q;
    evt          = '0;
    evt.kind     = KindEvent;
    evt.keycode  = work_q.base + CodeW'(r_idx) + CodeW'(1);
    if (|work_q.press) begin
      work_nx.press = work_q.press & (work_q.press - MaxRows'(1));
      evt.pressed   = 1'b1;
    end else if (|work_q.rel) begin
      work_nx.rel   = work_q.rel & (work_q.rel - MaxRows'(1));
      evt.pressed   = 1'b0;
    end else begin
      work_nx.summary = 1'b0;
      evt.kind        = KindSummary;
      evt.keycode     = '0;
      evt.any_held    = work_q.held;
    end
    evt.last = !((|work_nx.press) || (|work_nx.rel) || work_nx.summary);

    busy_after  = emit ? !evt.last : busy;
    job_ready_o = !busy_after;

    work_d = emit ? work_nx : work_q;
    if (job_valid_i && job_ready_o) begin
      work_d = job_i;
    end
  end

  // Work and output registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      work_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      work_q <= work_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (evt_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q <= evt;
    end
  end

  assign evt_o.valid = out_valid_q;
  assign evt_o.data  = out_q;

  `MKCD_ASSERT_IMP(a_summary_last, out_valid_q && (out_q.kind == KindSummary), out_q.last, "scan summary must close its request")
  `MKCD_ASSERT_IMP(a_event_fields, out_valid_q && (out_q.kind == KindEvent), (out_q.keycode != '0) && !out_q.any_held, "key event with bad keycode or held flag")
  `MKCD_ASSERT_NXT(a_no_bubble, busy && out_free, out_valid_q, "pending result not moved to output")

endmodule

>>> hdl/matrix_keypad_change_detector.sv
// ---------------------------------------------------------------------------
// Matrix keypad change detector
// Turns scanned keypad columns into press/release events and scan summaries.
// ---------------------------------------------------------------------------
// col_i carries one request per scanned column: column index, raw active-low
// row pins, display state and an end-of-scan flag. evt_o returns the events
// it causes: presses in ascending row order, then releases, then a summary
// (kind 1, any_held) when the column ends a scan. The last result of each
// request has last set; a request with no change and no scan end returns
// nothing.
// The first result of a request passes the job register, the serializer's
// work register and the output register. Throughput: one result per cycle
// from the serializer while the receiver takes them; a request causes at
// most ROWS + 1 results, and requests that cause none never reach it. One
// job waits in a register between detector and serializer, so a new request
// is taken while results of the previous one drain.
// Reset clears every stored column mask and the held accumulator. When the
// receiver stalls, the output register holds its result and the job register
// fills; the column channel then drops ready until space frees up.
// ---------------------------------------------------------------------------
module matrix_keypad_change_detector import mkcd_pkg::*; #(
  parameter int unsigned COLUMNS = 8,
  parameter int unsigned ROWS    = 10
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  mkcd_col_if.sink   col_i,
  mkcd_evt_if.source evt_o
);

  job_t job;
  logic job_valid, job_ready;

  // Column compare and mask store
  mkcd_detect #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_detect (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .col_i       (col_i),
    .job_o       (job),
    .job_valid_o (job_valid),
    .job_ready_i (job_ready)
  );

  // Event serializer and output register
  mkcd_serial u_serial (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (job),
    .job_valid_i (job_valid),
    .job_ready_o (job_ready),
    .evt_o       (evt_o)
  );

endmodule
